// ===== sv/asc_pkg.sv =====
// ----------------------------------------------------------------------------
// asc_pkg: shared constants for the sine contrast shaper
// Angle formats, CORDIC arctangent table and contrast scaling constants.
// ----------------------------------------------------------------------------
package asc_pkg;

  // angles and sines: signed, 28 fraction bits
  localparam int ANG_W  = 32;
  localparam int ANG_FRAC = 28;
  localparam int WIDE_W = 34;

  localparam logic signed [WIDE_W-1:0] Q_PI      = 34'sd843314857;
  localparam logic signed [WIDE_W-1:0] Q_HALF_PI = 34'sd421657428;
  localparam logic signed [WIDE_W-1:0] Q_TWO_PI  = 34'sd1686629713;

  // pi/2 as a multiplier operand for the sample-to-angle step
  localparam int HALF_PI_W = 31;
  localparam logic signed [HALF_PI_W-1:0] HALF_PI_M = 31'sd421657428;

  // CORDIC start value (inverse of the limit gain)
  localparam logic signed [ANG_W-1:0] CORDIC_GAIN = 32'sd163008218;

  localparam int ATAN_DEPTH = 24;
  localparam logic signed [ANG_W-1:0] ATAN_Q28 [ATAN_DEPTH] = '{
    32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
    32'sd16755422,  32'sd8385879,   32'sd4193963,  32'sd2097109,
    32'sd1048571,   32'sd524287,    32'sd262144,   32'sd131072,
    32'sd65536,     32'sd32768,     32'sd16384,    32'sd8192,
    32'sd4096,      32'sd2048,      32'sd1024,     32'sd512,
    32'sd256,       32'sd128,       32'sd64,       32'sd32
  };

  // contrast register
  localparam int CONTRAST_W = 15;
  localparam logic [CONTRAST_W-1:0] CONTRAST_RESET = 15'd8448;

  // term = round(contrast * s / 192000); 192000 = 2^9 * 375
  localparam int PROD_W    = 48;
  localparam int N_W       = 35;
  localparam int Q_W       = 27;
  localparam int REC_W     = 27;
  localparam int N_LO_W    = 18;
  localparam int REC_SHIFT = 35;
  localparam int QM_W      = 36;
  localparam logic [PROD_W-1:0] DIV_HALF = 48'd96000;
  localparam logic [REC_W-1:0]  DIV_REC  = 27'd91625968;
  localparam logic [8:0]        DIV_ODD  = 9'd375;

endpackage

// ===== sv/asc_if.sv =====
// ----------------------------------------------------------------------------
// asc_if: stream channels of the sine contrast shaper
// Sample input, sample output and contrast write channels, valid/ready.
// ----------------------------------------------------------------------------
interface asc_in_if #(parameter int SAMPLE_BITS = 16);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_in;
  logic                   frame_end;

  modport source (output valid, output sample_in, output frame_end, input ready);
  modport sink   (input valid, input sample_in, input frame_end, output ready);
endinterface

interface asc_out_if #(parameter int SAMPLE_BITS = 16);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_out;
  logic                   frame_end_out;

  modport source (output valid, output sample_out, output frame_end_out, input ready);
  modport sink   (input valid, input sample_out, input frame_end_out, output ready);
endinterface

interface asc_cfg_if;
  logic        valid;
  logic        ready;
  logic [14:0] contrast_q8;

  modport source (output valid, output contrast_q8, input ready);
  modport sink   (input valid, input contrast_q8, output ready);
endinterface

// ===== sv/asc_fold.sv =====
// ----------------------------------------------------------------------------
// asc_fold: angle reduction for the CORDIC
// Two stages: wrap into (-pi, pi], then fold into [-pi/2, pi/2].
// ----------------------------------------------------------------------------
module asc_fold #(
  parameter int SIDE_W = 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic signed [asc_pkg::ANG_W-1:0] t_in,
  input  logic [SIDE_W-1:0]               side_in,
  output logic                            out_valid,
  output logic signed [asc_pkg::ANG_W-1:0] z_out,
  output logic [SIDE_W-1:0]               side_out
);
  import asc_pkg::*;

  logic                      wrap_valid;
  logic signed [WIDE_W-1:0]  wrap;
  logic [SIDE_W-1:0]         wrap_side;
  logic signed [WIDE_W-1:0]  t_wide;
  logic signed [WIDE_W-1:0]  wrap_next;
  logic signed [WIDE_W-1:0]  fold_next;

  // wrap by one period
  always_comb begin
    t_wide = WIDE_W'(t_in);
    if (t_wide > Q_PI) begin
      wrap_next = t_wide - Q_TWO_PI;
    end else if (t_wide <= -Q_PI) begin
      wrap_next = t_wide + Q_TWO_PI;
    end else begin
      wrap_next = t_wide;
    end
  end

  // reflect the outer quarters
  always_comb begin
    if (wrap > Q_HALF_PI) begin
      fold_next = Q_PI - wrap;
    end else if (wrap < -Q_HALF_PI) begin
      fold_next = -Q_PI - wrap;
    end else begin
      fold_next = wrap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else if (en) begin
      wrap_valid <= in_valid;
      out_valid  <= wrap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wrap      <= wrap_next;
      wrap_side <= side_in;
      z_out     <= fold_next[ANG_W-1:0];
      side_out  <= wrap_side;
    end
  end

endmodule

// ===== sv/asc_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// asc_cordic_cell: one rotation-mode CORDIC micro-rotation
// Rotates (x, y) by +/- atan(2^-SHIFT) toward z = 0 and registers the result.
// ----------------------------------------------------------------------------
module asc_cordic_cell #(
  parameter int SHIFT  = 0,
  parameter int SIDE_W = 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic signed [asc_pkg::ANG_W-1:0] x_in,
  input  logic signed [asc_pkg::ANG_W-1:0] y_in,
  input  logic signed [asc_pkg::ANG_W-1:0] z_in,
  input  logic [SIDE_W-1:0]               side_in,
  output logic                            out_valid,
  output logic signed [asc_pkg::ANG_W-1:0] x_out,
  output logic signed [asc_pkg::ANG_W-1:0] y_out,
  output logic signed [asc_pkg::ANG_W-1:0] z_out,
  output logic [SIDE_W-1:0]               side_out
);
  import asc_pkg::*;

  localparam logic signed [ANG_W-1:0] ATAN = ATAN_Q28[SHIFT];

  logic                     ccw;
  logic signed [ANG_W-1:0]  x_sh;
  logic signed [ANG_W-1:0]  y_sh;

  assign ccw  = ~z_in[ANG_W-1];
  assign x_sh = x_in >>> SHIFT;
  assign y_sh = y_in >>> SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // rotate toward zero residual angle
  always_ff @(posedge clk) begin
    if (en) begin
      x_out    <= ccw ? (x_in - y_sh) : (x_in + y_sh);
      y_out    <= ccw ? (y_in + x_sh) : (y_in - x_sh);
      z_out    <= ccw ? (z_in - ATAN) : (z_in + ATAN);
      side_out <= side_in;
    end
  end

endmodule

// ===== sv/asc_cordic_chain.sv =====
// ----------------------------------------------------------------------------
// asc_cordic_chain: pipelined CORDIC sine
// A row of ITERATIONS cells, one micro-rotation per cell per enabled cycle.
// ----------------------------------------------------------------------------
module asc_cordic_chain #(
  parameter int ITERATIONS = 16,
  parameter int SIDE_W     = 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic signed [asc_pkg::ANG_W-1:0] z_in,
  input  logic [SIDE_W-1:0]               side_in,
  output logic                            out_valid,
  output logic signed [asc_pkg::ANG_W-1:0] sin_out,
  output logic [SIDE_W-1:0]               side_out
);
  import asc_pkg::*;

  logic                    vld  [ITERATIONS+1];
  logic signed [ANG_W-1:0] xs   [ITERATIONS+1];
  logic signed [ANG_W-1:0] ys   [ITERATIONS+1];
  logic signed [ANG_W-1:0] zs   [ITERATIONS+1];
  logic [SIDE_W-1:0]       sides[ITERATIONS+1];

  // start on the x axis, prescaled by the gain
  assign vld[0]   = in_valid;
  assign xs[0]    = CORDIC_GAIN;
  assign ys[0]    = '0;
  assign zs[0]    = z_in;
  assign sides[0] = side_in;

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
    asc_cordic_cell #(
      .SHIFT  (i),
      .SIDE_W (SIDE_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (vld[i]),
      .x_in      (xs[i]),
      .y_in      (ys[i]),
      .z_in      (zs[i]),
      .side_in   (sides[i]),
      .out_valid (vld[i+1]),
      .x_out     (xs[i+1]),
      .y_out     (ys[i+1]),
      .z_out     (zs[i+1]),
      .side_out  (sides[i+1])
    );
  end

  assign out_valid = vld[ITERATIONS];
  assign sin_out   = ys[ITERATIONS];
  assign side_out  = sides[ITERATIONS];

endmodule

// ===== sv/asc_term.sv =====
// ----------------------------------------------------------------------------
// asc_term: contrast term k * sin(4a)
// Multiplies by the contrast word and divides by 192000 with rounding half
// away from zero: shift by 2^9, then reciprocal multiply for 375 with one
// correction step. Six register stages.
// ----------------------------------------------------------------------------
module asc_term #(
  parameter int SIDE_W = 1
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic signed [asc_pkg::ANG_W-1:0]      sin_in,
  input  logic [asc_pkg::CONTRAST_W-1:0]        contrast,
  input  logic [SIDE_W-1:0]                    side_in,
  output logic                                 out_valid,
  output logic [asc_pkg::Q_W-1:0]               q_out,
  output logic                                 neg_out,
  output logic [SIDE_W-1:0]                    side_out
);
  import asc_pkg::*;

  localparam int PH_W  = (N_W - N_LO_W) + REC_W;
  localparam int PL_W  = N_LO_W + REC_W;
  localparam int SUM_W = N_W + REC_W;

  logic [5:0]                vld;
  logic [SIDE_W-1:0]         side1, side2, side3, side4, side5;
  logic signed [PROD_W-1:0]  prod;
  logic [N_W-1:0]            n2, n3, n4;
  logic                      neg2, neg3, neg4, neg5;
  logic [PH_W-1:0]           ph;
  logic [PL_W-1:0]           pl;
  logic [Q_W-1:0]            q0, q5;
  logic [QM_W-1:0]           qm;
  logic [N_W-1:0]            n5;

  logic [PROD_W-1:0]         mag;
  logic [PROD_W-1:0]         mag_rnd;
  logic [SUM_W-1:0]          sum;
  logic [QM_W-1:0]           rem;

  always_comb begin
    mag     = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
    mag_rnd = mag + DIV_HALF;
    sum     = {ph, {N_LO_W{1'b0}}} + SUM_W'(pl);
    rem     = QM_W'(n5) - qm;
  end

  // advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // signed product
      prod  <= PROD_W'($signed({1'b0, contrast})) * PROD_W'(sin_in);
      side1 <= side_in;
      // magnitude, half-divisor rounding, divide by 2^9
      n2    <= mag_rnd[N_W+8:9];
      neg2  <= prod[PROD_W-1];
      side2 <= side1;
      // reciprocal partial products
      ph    <= n2[N_W-1:N_LO_W] * DIV_REC;
      pl    <= n2[N_LO_W-1:0] * DIV_REC;
      n3    <= n2;
      neg3  <= neg2;
      side3 <= side2;
      // quotient estimate
      q0    <= sum[SUM_W-1:REC_SHIFT];
      n4    <= n3;
      neg4  <= neg3;
      side4 <= side3;
      // back-multiply by 375
      qm    <= QM_W'(q0) * QM_W'(DIV_ODD);
      q5    <= q0;
      n5    <= n4;
      neg5  <= neg4;
      side5 <= side4;
      // correct by one
      q_out    <= (rem >= QM_W'(DIV_ODD)) ? q5 + Q_W'(1) : q5;
      neg_out  <= neg5;
      side_out <= side5;
    end
  end

  assign out_valid = vld[5];

endmodule

// ===== sv/audio_sine_contrast_shaper.sv =====
// Throughput: one word per cycle while the skid word is empty; both sines run through
// CORDIC cell rows, one cell per stage.
// A two-word output register with skid keeps input open while one result waits.
// Reset: synchronous, active high; clears all valid bits, sets contrast to 33.0.
// ----------------------------------------------------------------------------
// audio_sine_contrast_shaper: sine-based audio contrast enhancement
// y = sin(a + k*sin(4a)), a = x*pi/2, k = contrast/750, saturated output.
// ----------------------------------------------------------------------------
module audio_sine_contrast_shaper #(
  parameter int SAMPLE_BITS     = 16,
  parameter int SINE_ITERATIONS = 16
) (
  input  logic clk,
  input  logic rst,
  asc_in_if.sink    din,
  asc_out_if.source dout,
  asc_cfg_if.sink   cfg
);
  import asc_pkg::*;

  localparam int FB  = SAMPLE_BITS - 1;
  localparam int PW  = SAMPLE_BITS + HALF_PI_W;
  localparam int RW  = 64;
  localparam int SHR = (FB <= ANG_FRAC) ? (ANG_FRAC - FB) : 0;
  localparam int SHL = (FB > ANG_FRAC) ? (FB - ANG_FRAC) : 0;
  localparam logic signed [PW-1:0] RND_A = {{(PW-1){1'b0}}, 1'b1} <<< (FB - 1);
  localparam logic signed [RW-1:0] RND_Y = (64'sd1 <<< SHR) >>> 1;
  localparam logic signed [RW-1:0] SMAX  = (64'sd1 <<< FB) - 64'sd1;
  localparam logic signed [RW-1:0] SMIN  = -SMAX - 64'sd1;
  localparam int SIDE1_W = ANG_W + 1;

  logic                        en;
  logic [CONTRAST_W-1:0]       contrast;

  logic                        p_vld;
  logic signed [PW-1:0]        p;
  logic                        p_fe;
  logic signed [PW-1:0]        p_rnd;

  logic                        a_vld;
  logic signed [ANG_W-1:0]     a;
  logic                        a_fe;

  logic                        f1_vld;
  logic signed [ANG_W-1:0]     f1_z;
  logic [SIDE1_W-1:0]          f1_side;

  logic                        c1_vld;
  logic signed [ANG_W-1:0]     c1_y;
  logic [SIDE1_W-1:0]          c1_side;

  logic                        tm_vld;
  logic [Q_W-1:0]              tm_q;
  logic                        tm_neg;
  logic [SIDE1_W-1:0]          tm_side;
  logic signed [ANG_W-1:0]     tm_a;
  logic signed [ANG_W-1:0]     tm_qs;

  logic                        b_vld;
  logic signed [ANG_W-1:0]     b;
  logic                        b_fe;

  logic                        f2_vld;
  logic signed [ANG_W-1:0]     f2_z;
  logic                        f2_fe;

  logic                        c2_vld;
  logic signed [ANG_W-1:0]     c2_y;
  logic                        c2_fe;

  logic signed [RW-1:0]        y_wide;
  logic [SAMPLE_BITS-1:0]      y_sat;

  logic                        r_vld;
  logic [SAMPLE_BITS-1:0]      r_sample;
  logic                        r_fe;

  logic                        o_vld;
  logic [SAMPLE_BITS-1:0]      o_sample;
  logic                        o_fe;
  logic                        s_vld;
  logic [SAMPLE_BITS-1:0]      s_sample;
  logic                        s_fe;

  // stall the core only while the skid word is occupied
  assign en        = ~s_vld;
  assign din.ready = en;
  assign cfg.ready = 1'b1;

  // contrast register
  always_ff @(posedge clk) begin
    if (rst) begin
      contrast <= CONTRAST_RESET;
    end else if (cfg.valid) begin
      contrast <= cfg.contrast_q8;
    end
  end

  // valid bits of the top-level stages
  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      r_vld <= 1'b0;
    end else if (en) begin
      p_vld <= din.valid;
      a_vld <= p_vld;
      b_vld <= tm_vld;
      r_vld <= c2_vld;
    end
  end

  // sample to angle: a = round(x * pi/2 / 2^FB)
  assign p_rnd = p + RND_A;

  // apply the contrast term with its sign
  assign tm_a  = tm_side[SIDE1_W-1:1];
  assign tm_qs = ANG_W'(tm_q);

  always_ff @(posedge clk) begin
    if (en) begin
      p    <= PW'($signed(din.sample_in)) * PW'(HALF_PI_M);
      p_fe <= din.frame_end;
      a    <= ANG_W'(p_rnd >>> FB);
      a_fe <= p_fe;
      b    <= tm_neg ? (tm_a - tm_qs) : (tm_a + tm_qs);
      b_fe <= tm_side[0];
    end
  end

  asc_fold #(.SIDE_W(SIDE1_W)) u_fold_4a (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (a_vld),
    .t_in      (a <<< 2),
    .side_in   ({a, a_fe}),
    .out_valid (f1_vld),
    .z_out     (f1_z),
    .side_out  (f1_side)
  );

  asc_cordic_chain #(
    .ITERATIONS (SINE_ITERATIONS),
    .SIDE_W     (SIDE1_W)
  ) u_sin_4a (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f1_vld),
    .z_in      (f1_z),
    .side_in   (f1_side),
    .out_valid (c1_vld),
    .sin_out   (c1_y),
    .side_out  (c1_side)
  );

  asc_term #(.SIDE_W(SIDE1_W)) u_term (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (c1_vld),
    .sin_in    (c1_y),
    .contrast  (contrast),
    .side_in   (c1_side),
    .out_valid (tm_vld),
    .q_out     (tm_q),
    .neg_out   (tm_neg),
    .side_out  (tm_side)
  );

  asc_fold #(.SIDE_W(1)) u_fold_b (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (b_vld),
    .t_in      (b),
    .side_in   (b_fe),
    .out_valid (f2_vld),
    .z_out     (f2_z),
    .side_out  (f2_fe)
  );

  asc_cordic_chain #(
    .ITERATIONS (SINE_ITERATIONS),
    .SIDE_W     (1)
  ) u_sin_b (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f2_vld),
    .z_in      (f2_z),
    .side_in   (f2_fe),
    .out_valid (c2_vld),
    .sin_out   (c2_y),
    .side_out  (c2_fe)
  );

  // round to the sample format and saturate
  always_comb begin
    y_wide = ((RW'(c2_y) + RND_Y) >>> SHR) <<< SHL;
    if (y_wide > SMAX) begin
      y_sat = SMAX[SAMPLE_BITS-1:0];
    end else if (y_wide < SMIN) begin
      y_sat = SMIN[SAMPLE_BITS-1:0];
    end else begin
      y_sat = y_wide[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_sample <= y_sat;
      r_fe     <= c2_fe;
    end
  end

  // output word and skid word
  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
      s_vld <= 1'b0;
    end else if (s_vld) begin
      if (dout.ready) begin
        s_vld <= 1'b0;
      end
    end else if (r_vld) begin
      if (o_vld && !dout.ready) begin
        s_vld <= 1'b1;
      end else begin
        o_vld <= 1'b1;
      end
    end else if (dout.ready) begin
      o_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_vld) begin
      if (dout.ready) begin
        o_sample <= s_sample;
        o_fe     <= s_fe;
      end
    end else if (r_vld) begin
      if (o_vld && !dout.ready) begin
        s_sample <= r_sample;
        s_fe     <= r_fe;
      end else begin
        o_sample <= r_sample;
        o_fe     <= r_fe;
      end
    end
  end

  assign dout.valid         = o_vld;
  assign dout.sample_out    = o_sample;
  assign dout.frame_end_out = o_fe;

endmodule

// ===== sv/asc_checker.sv =====
// ----------------------------------------------------------------------------
// asc_checker: port-level checks for the sine contrast shaper
// Watches the handshakes and the count of words in flight.
// ----------------------------------------------------------------------------
module asc_checker #(
  parameter int SAMPLE_BITS     = 16,
  parameter int SINE_ITERATIONS = 16
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] sample_out,
  input logic                   frame_end_out,
  input logic                   cfg_ready
);

  localparam int PEND_W = $clog2(2 * SINE_ITERATIONS + 20);

  logic [PEND_W-1:0] pending;
  logic              in_acc;
  logic              out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // count words accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_acc && !out_acc) begin
      pending <= pending + PEND_W'(1);
    end else if (out_acc && !in_acc) begin
      pending <= pending - PEND_W'(1);
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(frame_end_out))
    else $error("result changed while stalled");

  // no result without an accepted word behind it
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != '0)
    else $error("result delivered with nothing in flight");

  // input stays open unless a result is waiting
  a_open_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input closed with the output empty");

  // configuration writes are always taken
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("configuration channel not ready");

endmodule

bind audio_sine_contrast_shaper asc_checker #(
  .SAMPLE_BITS     (SAMPLE_BITS),
  .SINE_ITERATIONS (SINE_ITERATIONS)
) u_asc_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (din.valid),
  .in_ready      (din.ready),
  .out_valid     (dout.valid),
  .out_ready     (dout.ready),
  .sample_out    (dout.sample_out),
  .frame_end_out (dout.frame_end_out),
  .cfg_ready     (cfg.ready)
);
